// ----- src/iirdf1_pkg.sv -----
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared types and constants for the direct form I IIR filter: the
// configuration register map, the coefficient format and the tap limits.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_W          = 18;
  localparam int COEF_FRAC_BITS  = 14;
  localparam int CFG_IDX_W       = 3;
  localparam int COUNT_W         = 2;

  localparam logic [COUNT_W-1:0] FF_TAPS = 2'd3;
  localparam logic [COUNT_W-1:0] FB_TAPS = 2'd2;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [COUNT_W-1:0]       count_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_NEWEST = 3'd0,
    REG_FF_MID    = 3'd1,
    REG_FF_OLDEST = 3'd2,
    REG_FB_RECENT = 3'd3,
    REG_FB_OLDER  = 3'd4,
    REG_FF_COUNT  = 3'd5,
    REG_FB_COUNT  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    coef_t  ff_newest;
    coef_t  ff_mid;
    coef_t  ff_oldest;
    coef_t  fb_recent;
    coef_t  fb_older;
    count_t ff_count;
    count_t fb_count;
  } cfg_t;

  localparam coef_t  FF_NEWEST_RST = 18'sd16384;
  localparam count_t FF_COUNT_RST  = 2'd1;

endpackage

// ----- src/iirdf1_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// iirdf1_cfg_regs
// Configuration register bank: coefficients and tap counts, written one word
// at a time through the configuration channel.
// ----------------------------------------------------------------------------
module iirdf1_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iirdf1_pkg::COEF_W-1:0]        cfg_data,
  output iirdf1_pkg::cfg_t                     cfg
);

  iirdf1_pkg::cfg_t cfg_r;
  iirdf1_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (iirdf1_pkg::reg_idx_t'(cfg_index))
        iirdf1_pkg::REG_FF_NEWEST: cfg_nxt.ff_newest = cfg_data;
        iirdf1_pkg::REG_FF_MID:    cfg_nxt.ff_mid    = cfg_data;
        iirdf1_pkg::REG_FF_OLDEST: cfg_nxt.ff_oldest = cfg_data;
        iirdf1_pkg::REG_FB_RECENT: cfg_nxt.fb_recent = cfg_data;
        iirdf1_pkg::REG_FB_OLDER:  cfg_nxt.fb_older  = cfg_data;
        iirdf1_pkg::REG_FF_COUNT:  cfg_nxt.ff_count  = cfg_data[iirdf1_pkg::COUNT_W-1:0];
        iirdf1_pkg::REG_FB_COUNT:  cfg_nxt.fb_count  = cfg_data[iirdf1_pkg::COUNT_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r           <= '0;
      cfg_r.ff_newest <= iirdf1_pkg::FF_NEWEST_RST;
      cfg_r.ff_count  <= iirdf1_pkg::FF_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- src/iirdf1_core.sv -----
// ----------------------------------------------------------------------------
// iirdf1_core
// Filter arithmetic for one sample: five parallel products, full-width sum,
// round to nearest, saturation and the warm-up bypass.
// ----------------------------------------------------------------------------
module iirdf1_core #(
  parameter int SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS_DEF
) (
  input  iirdf1_pkg::cfg_t                 cfg,
  input  iirdf1_pkg::count_t               warm,
  input  logic signed [SAMPLE_BITS-1:0]    x,
  input  logic signed [SAMPLE_BITS-1:0]    x_hist0,
  input  logic signed [SAMPLE_BITS-1:0]    x_hist1,
  input  logic signed [SAMPLE_BITS-1:0]    y_hist0,
  input  logic signed [SAMPLE_BITS-1:0]    y_hist1,
  output logic signed [SAMPLE_BITS-1:0]    y,
  output logic                             clip
);

  localparam int PW   = SAMPLE_BITS + iirdf1_pkg::COEF_W;
  localparam int AW   = PW + 3;
  localparam int FRAC = iirdf1_pkg::COEF_FRAC_BITS;
  localparam int RW   = AW - FRAC;
  localparam logic signed [AW-1:0] HALF  = AW'(2 ** (FRAC - 1));
  localparam logic signed [RW-1:0] S_MAX = RW'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [RW-1:0] S_MIN = RW'(-(2 ** (SAMPLE_BITS - 1)));

  iirdf1_pkg::count_t          nff;
  iirdf1_pkg::count_t          nfb;
  iirdf1_pkg::count_t          dff;
  iirdf1_pkg::count_t          delay;
  logic signed [SAMPLE_BITS-1:0] op0, op1, op2, op3, op4;
  logic signed [PW-1:0]        p0, p1, p2, p3, p4;
  logic signed [AW-1:0]        acc;
  logic signed [AW-1:0]        rnd;
  logic signed [AW-1:0]        shifted;
  logic signed [RW-1:0]        res;

  always_comb begin
    nff   = (cfg.ff_count > iirdf1_pkg::FF_TAPS) ? iirdf1_pkg::FF_TAPS : cfg.ff_count;
    nfb   = (cfg.fb_count > iirdf1_pkg::FB_TAPS) ? iirdf1_pkg::FB_TAPS : cfg.fb_count;
    dff   = (nff == 2'd0) ? 2'd0 : nff - 2'd1;
    delay = (nfb > dff) ? nfb : dff;

    op0 = (nff > 2'd0) ? x       : '0;
    op1 = (nff > 2'd1) ? x_hist0 : '0;
    op2 = (nff > 2'd2) ? x_hist1 : '0;
    op3 = (nfb > 2'd0) ? y_hist0 : '0;
    op4 = (nfb > 2'd1) ? y_hist1 : '0;

    p0 = PW'(cfg.ff_newest) * PW'(op0);
    p1 = PW'(cfg.ff_mid)    * PW'(op1);
    p2 = PW'(cfg.ff_oldest) * PW'(op2);
    p3 = PW'(cfg.fb_recent) * PW'(op3);
    p4 = PW'(cfg.fb_older)  * PW'(op4);

    acc     = AW'(p0) + AW'(p1) + AW'(p2) - AW'(p3) - AW'(p4);
    rnd     = acc + HALF;
    shifted = rnd >>> FRAC;
    res     = shifted[RW-1:0];

    if (warm < delay) begin
      y    = x;
      clip = 1'b0;
    end else if (res > S_MAX) begin
      y    = S_MAX[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else if (res < S_MIN) begin
      y    = S_MIN[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else begin
      y    = res[SAMPLE_BITS-1:0];
      clip = 1'b0;
    end
  end

endmodule

// ----- src/iir_direct_form_one_filter.sv -----
// A sample waits in the input register; its result is formed combinationally and
// is loaded into the result register once that register is empty or being read.
// Throughput: one sample per cycle unless the output stalls; the feedback loop
// closes through the history registers, which load with the result register.
// Reset (synchronous, active low) empties both stages, clears the histories and
// the warm-up count, and loads the coefficient reset values.
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// Direct form I IIR filter with up to three feedforward and two feedback taps,
// Q4.14 coefficients, rounding, saturation and a run-end history clear.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter #(
  parameter int SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iirdf1_pkg::COEF_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  input  logic                                in_run_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_out,
  output logic                                out_clipped
);

  iirdf1_pkg::cfg_t              cfg;
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          s1_run_end_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_clipped_r;
  logic signed [SAMPLE_BITS-1:0] x_hist0_r, x_hist1_r;
  logic signed [SAMPLE_BITS-1:0] y_hist0_r, y_hist1_r;
  iirdf1_pkg::count_t            warm_r;
  iirdf1_pkg::count_t            warm_nxt;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                          clip;
  logic                          advance;

  iirdf1_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  iirdf1_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .cfg     (cfg),
    .warm    (warm_r),
    .x       (s1_sample_r),
    .x_hist0 (x_hist0_r),
    .x_hist1 (x_hist1_r),
    .y_hist0 (y_hist0_r),
    .y_hist1 (y_hist1_r),
    .y       (y),
    .clip    (clip)
  );

  assign advance        = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready       = !s1_valid_r || advance;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;
  assign warm_nxt       = (warm_r == 2'd3) ? warm_r : warm_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      x_hist0_r   <= '0;
      x_hist1_r   <= '0;
      y_hist0_r   <= '0;
      y_hist1_r   <= '0;
      warm_r      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        if (s1_run_end_r) begin
          x_hist0_r <= '0;
          x_hist1_r <= '0;
          y_hist0_r <= '0;
          y_hist1_r <= '0;
          warm_r    <= '0;
        end else begin
          x_hist0_r <= s1_sample_r;
          x_hist1_r <= x_hist0_r;
          y_hist0_r <= y;
          y_hist1_r <= y_hist0_r;
          warm_r    <= warm_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample_r  <= in_sample_in;
      s1_run_end_r <= in_run_end;
    end
    if (advance) begin
      out_sample_r  <= y;
      out_clipped_r <= clip;
    end
  end

endmodule

// ----- src/iirdf1_checker.sv -----
// ----------------------------------------------------------------------------
// iirdf1_checker
// Port-level checks for the IIR filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module iirdf1_checker #(
  parameter int SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input logic                          out_clipped
);

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = SAMPLE_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = SAMPLE_BITS'(-(2 ** (SAMPLE_BITS - 1)));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample_out) && $stable(out_clipped))
    else $error("result word changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_sample_out == S_MAX || out_sample_out == S_MIN)
    else $error("clipped word not at a saturation limit");

endmodule

bind iir_direct_form_one_filter iirdf1_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out),
  .out_clipped    (out_clipped)
);

// ----- tb/sv/iir_direct_form_one_filter_test.sv -----
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter_test
// Self-checking bench for the direct form I IIR filter. A directed table runs
// through reset behaviour, saturation, rounding, warm-up and run ends. Random
// phases then load fresh coefficients and tap counts and stream samples. Every
// output word is checked against the table's expected value or an in-bench
// filter model. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = iirdf1_pkg::SAMPLE_BITS_DEF;
  localparam int IW = iirdf1_pkg::CFG_IDX_W;
  localparam int CW = iirdf1_pkg::COEF_W;
  localparam longint SMAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam logic [IW-1:0] REG_NONE = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 36;
  localparam int PLAN_LEN = 34;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 clip;
  } filt_word_t;

  typedef struct {
    bit                   cfg;
    logic [IW-1:0]        idx;
    logic [CW-1:0]        data;
    logic signed [SW-1:0] sample;
    bit                   last;
    bit                   typed;
    logic signed [SW-1:0] want_sample;
    bit                   want_clip;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IW-1:0]        cfg_index;
  logic [CW-1:0]        cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [SW-1:0] in_sample_in;
  logic                 in_run_end;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [SW-1:0] out_sample_out;
  logic                 out_clipped;

  bit                   cur_typed;
  logic signed [SW-1:0] cur_want_sample;
  bit                   cur_want_clip;

  filt_word_t pending_out[$];
  int errors;
  int stall_cycles;
  int burst_left;
  bit hold_req;
  int hold_left;
  int rx_mode;
  int rx_tick;

  iirdf1_pkg::coef_t    ff_w[3];
  iirdf1_pkg::coef_t    fb_w[2];
  iirdf1_pkg::count_t   ff_n;
  iirdf1_pkg::count_t   fb_n;
  logic signed [SW-1:0] in_hist[2];
  logic signed [SW-1:0] out_hist[2];
  logic [1:0]           warm;

  plan_row_t directed_plan [PLAN_LEN] = '{
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,  32767, 0, 1,  32767, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0, -32768, 0, 1, -32768, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,      0, 0, 1,      0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,     -1, 0, 1,     -1, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,  21845, 1, 1,  21845, 0},
    '{1, iirdf1_pkg::REG_FF_NEWEST, 131071, 0, 0, 0, 0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,  32767, 0, 1,  32767, 1},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0, -32768, 0, 1, -32768, 1},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,      1, 0, 1,      8, 0},
    '{1, iirdf1_pkg::REG_FF_NEWEST, -131072, 0, 0, 0, 0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0, -32768, 0, 1,  32767, 1},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,  32767, 0, 1, -32768, 1},
    '{1, iirdf1_pkg::REG_FF_NEWEST, 8192, 0, 0, 0, 0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,      1, 0, 1,      1, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,     -1, 0, 1,      0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,     -3, 0, 1,     -1, 0},
    '{1, iirdf1_pkg::REG_FF_COUNT, 0, 0, 0, 0, 0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,  12345, 1, 1,      0, 0},
    '{1, iirdf1_pkg::REG_FF_MID, 5000, 0, 0, 0, 0, 0},
    '{1, iirdf1_pkg::REG_FF_OLDEST, -7000, 0, 0, 0, 0, 0},
    '{1, iirdf1_pkg::REG_FB_RECENT, 3000, 0, 0, 0, 0, 0},
    '{1, iirdf1_pkg::REG_FB_OLDER, -2000, 0, 0, 0, 0, 0},
    '{1, iirdf1_pkg::REG_FF_COUNT, 3, 0, 0, 0, 0, 0},
    '{1, iirdf1_pkg::REG_FB_COUNT, 3, 0, 0, 0, 0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,   1000, 0, 1,   1000, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,  -2000, 0, 1,  -2000, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,  30000, 0, 0,      0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0, -30000, 0, 0,      0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,    777, 1, 0,      0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,    500, 0, 1,    500, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,    600, 0, 1,    600, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,    700, 1, 0,      0, 0},
    '{1, REG_NONE, 262143, 0, 0, 0, 0, 0},
    '{0, iirdf1_pkg::REG_FF_NEWEST, 0,    100, 0, 1,    100, 0}
  };

  iir_direct_form_one_filter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .in_run_end    (in_run_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_clipped   (out_clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_history();
    in_hist  = '{default: '0};
    out_hist = '{default: '0};
    warm     = '0;
  endfunction

  function automatic void apply_reg(logic [IW-1:0] idx, logic [CW-1:0] data);
    case (idx)
      iirdf1_pkg::REG_FF_NEWEST: ff_w[0] = iirdf1_pkg::coef_t'(data);
      iirdf1_pkg::REG_FF_MID:    ff_w[1] = iirdf1_pkg::coef_t'(data);
      iirdf1_pkg::REG_FF_OLDEST: ff_w[2] = iirdf1_pkg::coef_t'(data);
      iirdf1_pkg::REG_FB_RECENT: fb_w[0] = iirdf1_pkg::coef_t'(data);
      iirdf1_pkg::REG_FB_OLDER:  fb_w[1] = iirdf1_pkg::coef_t'(data);
      iirdf1_pkg::REG_FF_COUNT:  ff_n = data[iirdf1_pkg::COUNT_W-1:0];
      iirdf1_pkg::REG_FB_COUNT:  fb_n = data[iirdf1_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void filter_predict(input logic signed [SW-1:0] x, input logic last,
                                         output logic signed [SW-1:0] y, output logic clip);
    iirdf1_pkg::count_t   nff;
    iirdf1_pkg::count_t   nfb;
    iirdf1_pkg::count_t   settle_len;
    logic signed [SW-1:0] tap;
    longint               acc;
    longint               r;
    nff = (ff_n > iirdf1_pkg::FF_TAPS) ? iirdf1_pkg::FF_TAPS : ff_n;
    nfb = (fb_n > iirdf1_pkg::FB_TAPS) ? iirdf1_pkg::FB_TAPS : fb_n;
    settle_len = (nff > 0) ? iirdf1_pkg::count_t'(nff - 1) : iirdf1_pkg::count_t'(0);
    if (nfb > settle_len) settle_len = nfb;
    clip = 1'b0;
    if (warm < settle_len) begin
      y = x;
    end else begin
      acc = 0;
      for (int i = 0; i < int'(nff); i++) begin
        tap = (i == 0) ? x : in_hist[i-1];
        acc += longint'(ff_w[i]) * longint'(tap);
      end
      for (int i = 0; i < int'(nfb); i++) begin
        acc -= longint'(fb_w[i]) * longint'(out_hist[i]);
      end
      r = (acc + (longint'(1) <<< (iirdf1_pkg::COEF_FRAC_BITS - 1)))
          >>> iirdf1_pkg::COEF_FRAC_BITS;
      if (r > SMAX) begin
        r = SMAX;
        clip = 1'b1;
      end else if (r < SMIN) begin
        r = SMIN;
        clip = 1'b1;
      end
      y = SW'(r);
    end
    in_hist[1]  = in_hist[0];
    in_hist[0]  = x;
    out_hist[1] = out_hist[0];
    out_hist[0] = y;
    if (warm < 2'd3) warm++;
    if (last) clear_history();
  endfunction

  always @(posedge clk) begin : monitor
    filt_word_t           want;
    logic signed [SW-1:0] pred_sample;
    logic                 pred_clip;
    if (!rst_n) begin
      ff_w = '{iirdf1_pkg::FF_NEWEST_RST, '0, '0};
      fb_w = '{default: '0};
      ff_n = iirdf1_pkg::FF_COUNT_RST;
      fb_n = '0;
      clear_history();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_out.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got sample_out %0d clipped %0b",
                   $time, out_sample_out, out_clipped);
        end else begin
          want = pending_out.pop_front();
          if (out_sample_out !== want.sample) begin
            errors++;
            $display("%0t: sample_out expected %0d, got %0d", $time, want.sample,
                     out_sample_out);
          end
          if (out_clipped !== want.clip) begin
            errors++;
            $display("%0t: clipped expected %0b, got %0b", $time, want.clip, out_clipped);
          end
        end
      end
      if (in_valid && in_ready) begin
        filter_predict(in_sample_in, in_run_end, pred_sample, pred_clip);
        if (cur_typed) pending_out.push_back('{cur_want_sample, cur_want_clip});
        else pending_out.push_back('{pred_sample, pred_clip});
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(0, 1) == 0);
        2: out_ready = (rx_tick % 3 == 0);
        default: out_ready = ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  task automatic drive_sample(logic signed [SW-1:0] sample, bit last, bit typed,
                              logic signed [SW-1:0] want_sample, bit want_clip);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_sample_in    = sample;
    in_run_end      = last;
    cur_typed       = typed;
    cur_want_sample = want_sample;
    cur_want_clip   = want_clip;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [CW-1:0] pick_coef(int mode);
    if (mode == 0) return CW'(131071);
    if (mode == 1) return CW'(-131072);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CW'(131071);
      2: return CW'(-131072);
      3, 4: return CW'(int'($urandom_range(0, 32768)) - 16384);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SW'(SMAX);
      1: return SW'(SMIN);
      2, 3: return SW'(int'($urandom_range(0, 400)) - 200);
      default: return SW'($urandom);
    endcase
  endfunction

  initial begin
    logic [CW-1:0] count_word;
    int            mode;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_sample_in    = '0;
    in_run_end      = 1'b0;
    out_ready       = 1'b0;
    cur_typed       = 1'b0;
    cur_want_sample = '0;
    cur_want_clip   = 1'b0;
    errors          = 0;
    stall_cycles    = 0;
    burst_left      = 0;
    hold_req        = 1'b0;
    hold_left       = 0;
    rx_mode         = 0;
    rx_tick         = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_plan[k]) begin
      if (directed_plan[k].cfg) begin
        wait_for_drain();
        write_reg(directed_plan[k].idx, directed_plan[k].data);
      end else begin
        drive_sample(directed_plan[k].sample, directed_plan[k].last, directed_plan[k].typed,
                     directed_plan[k].want_sample, directed_plan[k].want_clip);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_for_drain();
      mode = (p < 2) ? p : 2;
      write_reg(iirdf1_pkg::REG_FF_NEWEST, pick_coef(mode));
      write_reg(iirdf1_pkg::REG_FF_MID, pick_coef(mode));
      write_reg(iirdf1_pkg::REG_FF_OLDEST, pick_coef(mode));
      write_reg(iirdf1_pkg::REG_FB_RECENT, pick_coef(mode));
      write_reg(iirdf1_pkg::REG_FB_OLDER, pick_coef(mode));
      count_word = CW'($urandom);
      count_word[iirdf1_pkg::COUNT_W-1:0] =
        (mode == 0) ? 2'd3 : (mode == 1) ? 2'd0 : 2'($urandom);
      write_reg(iirdf1_pkg::REG_FF_COUNT, count_word);
      count_word = CW'($urandom);
      count_word[iirdf1_pkg::COUNT_W-1:0] =
        (mode == 0) ? 2'd3 : (mode == 1) ? 2'd0 : 2'($urandom);
      write_reg(iirdf1_pkg::REG_FB_COUNT, count_word);
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, CW'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 10) hold_req = 1'b1;
        drive_sample(pick_sample(), ($urandom_range(0, 15) == 0), 1'b0, '0, 1'b0);
      end
    end

    wait_for_drain();
    repeat (8) @(negedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
src/iirdf1_pkg.sv
src/iirdf1_cfg_regs.sv
src/iirdf1_core.sv
src/iir_direct_form_one_filter.sv
src/iirdf1_checker.sv
tb/sv/iir_direct_form_one_filter_test.sv
